// ===== hdl/rms_pkg.sv =====
// Shared types, constants and helpers for the range-minimum segment tree.
package rms_pkg;

  localparam int unsigned LEAVES_DEFAULT = 1024;
  localparam int unsigned POS_W          = 10;
  localparam int unsigned DELTA_W        = 32;
  localparam int unsigned VAL_W          = 48;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [POS_W-1:0]          position;
    logic signed [DELTA_W-1:0] delta;
    logic [POS_W-1:0]          range_start;
    logic [POS_W-1:0]          range_end;
  } rms_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] minimum;
    logic                    empty_range;
  } rms_out_t;

  typedef struct packed {
    logic     valid;
    rms_out_t data;
  } rms_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_UP,
    ST_QLO,
    ST_QHI,
    ST_DONE
  } rms_state_t;

  function automatic logic signed [VAL_W-1:0] lesser(input logic signed [VAL_W-1:0] a,
                                                     input logic signed [VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== hdl/rms_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rms_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/rms_ctrl.sv =====
// Sequencer: clear sweep, leaf update with path refresh, and range-minimum walk.
module rms_ctrl #(
  parameter int unsigned LEAVES = rms_pkg::LEAVES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  rms_pkg::rms_in_t                    req,
  input  logic                                res_room,
  output rms_pkg::rms_res_t                   res,
  output logic                                we,
  output logic [$clog2(2*LEAVES)-1:0]         waddr,
  output logic signed [rms_pkg::VAL_W-1:0]    wdata,
  output logic                                re,
  output logic [$clog2(2*LEAVES)-1:0]         raddr,
  input  logic signed [rms_pkg::VAL_W-1:0]    rdata
);
  import rms_pkg::*;

  localparam int unsigned AW = $clog2(2*LEAVES);
  localparam int unsigned HW = $clog2(2*LEAVES+1);
  localparam logic [AW-1:0] LastNode = AW'(2*LEAVES-1);
  localparam logic [AW-1:0] RootNode = AW'(1);

  rms_state_t state, state_next;
  logic [AW-1:0]           node, node_next;
  logic [AW-1:0]           clr, clr_next;
  logic signed [VAL_W-1:0] cur, cur_next;
  logic signed [DELTA_W-1:0] delta, delta_next;
  logic [HW-1:0]           lo, lo_next, hi, hi_next, hi_dec;
  logic signed [VAL_W-1:0] best, best_next, folded;
  logic                    pend, pend_next;
  logic                    empty, empty_next;

  logic [31:0]             start32, end32, last32;
  logic [AW-1:0]           parent;
  logic signed [VAL_W:0]   sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    node  <= node_next;
    cur   <= cur_next;
    delta <= delta_next;
    lo    <= lo_next;
    hi    <= hi_next;
    best  <= best_next;
    empty <= empty_next;
  end

  always_comb begin
    start32 = 32'(req.range_start);
    end32   = 32'(req.range_end);
    last32  = (end32 > 32'(LEAVES-1)) ? 32'(LEAVES-1) : end32;
    parent  = node >> 1;
    sum     = {rdata[VAL_W-1], rdata} + (VAL_W+1)'(delta);
    folded  = pend ? lesser(best, rdata) : best;
    hi_dec  = hi - HW'(hi[0]);

    state_next = state;
    clr_next   = clr;
    node_next  = node;
    cur_next   = cur;
    delta_next = delta;
    lo_next    = lo;
    hi_next    = hi;
    best_next  = best;
    pend_next  = 1'b0;
    empty_next = empty;

    req_ready = 1'b0;
    we        = 1'b0;
    waddr     = node;
    wdata     = cur;
    re        = 1'b0;
    raddr     = node;
    res.valid = 1'b0;
    res.data.minimum     = best;
    res.data.empty_range = empty;

    case (state)
      ST_CLEAR: begin
        we       = 1'b1;
        waddr    = clr;
        wdata    = '0;
        clr_next = clr + AW'(1);
        if (clr == LastNode) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.mode == MODE_ADD) begin
            // drop adds beyond the array
            if (32'(req.position) < 32'(LEAVES)) begin
              node_next  = AW'(32'(req.position) + 32'(LEAVES));
              delta_next = req.delta;
              re         = 1'b1;
              raddr      = AW'(32'(req.position) + 32'(LEAVES));
              state_next = ST_LEAF;
            end
          end else if (start32 > last32) begin
            best_next  = '0;
            empty_next = 1'b1;
            state_next = ST_DONE;
          end else begin
            lo_next    = HW'(start32 + 32'(LEAVES));
            hi_next    = HW'(last32 + 32'(LEAVES) + 32'd1);
            best_next  = VAL_MAX;
            empty_next = 1'b0;
            state_next = ST_QLO;
          end
        end
      end
      ST_LEAF: begin
        if (sum[VAL_W] != sum[VAL_W-1]) begin
          cur_next = sum[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
          cur_next = sum[VAL_W-1:0];
        end
        we         = 1'b1;
        waddr      = node;
        wdata      = cur_next;
        re         = 1'b1;
        raddr      = node ^ AW'(1);
        state_next = ST_UP;
      end
      ST_UP: begin
        // sibling arrives now; write parent and, unless it is the root, fetch its sibling
        cur_next  = lesser(cur, rdata);
        we        = 1'b1;
        waddr     = parent;
        wdata     = cur_next;
        node_next = parent;
        if (parent == RootNode) begin
          state_next = ST_IDLE;
        end else begin
          re    = 1'b1;
          raddr = parent ^ AW'(1);
        end
      end
      ST_QLO: begin
        best_next = folded;
        if (lo < hi) begin
          if (lo[0]) begin
            re        = 1'b1;
            raddr     = lo[AW-1:0];
            lo_next   = lo + HW'(1);
            pend_next = 1'b1;
          end
          state_next = ST_QHI;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_QHI: begin
        best_next = folded;
        if (hi[0]) begin
          re        = 1'b1;
          raddr     = hi_dec[AW-1:0];
          pend_next = 1'b1;
        end
        lo_next    = lo >> 1;
        hi_next    = hi_dec >> 1;
        state_next = ST_QLO;
      end
      ST_DONE: begin
        // hold until the output register has room
        if (res_room) begin
          res.valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_rw_distinct: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("read and write hit the same node in one cycle");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QLO || state == ST_QHI) |-> (lo <= hi))
    else $error("query bounds crossed");

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res_room)
    else $error("result issued with output register full");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_ready && req_valid) |=> (state != ST_CLEAR && $past(state) == ST_IDLE))
    else $error("item taken outside idle");

endmodule

// ===== hdl/range_min_segment_tree.sv =====
// Top level: range-minimum segment tree with node memory and output register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  rms_in_t  (mode, position, delta, range)
//   rsp      out        rsp_valid / rsp_ready  rms_out_t (minimum, empty_range)
//
// After reset the node memory is cleared, one node a cycle, with req_ready low. An add
// reads the leaf, writes it back with the delta added while reading its sibling, then
// writes each parent up the path and reads its sibling on the single read port. A
// query does the accept, a left and a right boundary read per level over up to
// log2(LEAVES) + 1 levels, a closing compare and the result issue. An empty range goes
// straight to the result issue; an out-of-range add is dropped. A stalled rsp holds
// one result while the next item is worked on; a second result waits in the sequencer.
module range_min_segment_tree #(
  parameter int unsigned LEAVES = rms_pkg::LEAVES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  rms_pkg::rms_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rms_pkg::rms_out_t rsp
);
  import rms_pkg::*;

  localparam int unsigned AW = $clog2(2*LEAVES);

  rms_res_t                res;
  logic                    res_room;
  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic signed [VAL_W-1:0] wdata, rdata;

  assign res_room = !rsp_valid || rsp_ready;

  rms_ctrl #(
    .LEAVES(LEAVES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_room (res_room),
    .res      (res),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  rms_ram #(
    .WIDTH(VAL_W),
    .DEPTH(2*LEAVES)
  ) u_nodes (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res.valid) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      rsp <= res.data;
    end
  end

endmodule
